/* src/olhs_pkg.sv */
// Shared types, field positions and codes for the object list header step unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package olhs_pkg;

   // Stream widths
   localparam int REQ_TDATA_W = 232;
   localparam int RSP_TDATA_W = 160;

   // Request field positions in req_tdata
   localparam int ADDR_W       = 24;
   localparam int PHRASE_W     = 64;
   localparam int HALFLINE_W   = 11;
   localparam int REQ_ADDR_LSB = 0;
   localparam int REQ_HDR_LSB  = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_SEC_LSB  = REQ_HDR_LSB + PHRASE_W;
   localparam int REQ_THD_LSB  = REQ_SEC_LSB + PHRASE_W;
   localparam int REQ_HL_LSB   = REQ_THD_LSB + PHRASE_W;
   localparam int REQ_OPF_BIT  = REQ_HL_LSB + HALFLINE_W;
   localparam int REQ_HALF_BIT = REQ_OPF_BIT + 1;

   // Result field positions in rsp_tdata
   localparam int NEXT_W         = 22;
   localparam int ACTION_W       = 3;
   localparam int RSP_NEXT_LSB   = 0;
   localparam int RSP_IRQ_BIT    = RSP_NEXT_LSB + NEXT_W;
   localparam int RSP_WH_BIT     = RSP_IRQ_BIT + 1;
   localparam int RSP_HDR_LSB    = RSP_WH_BIT + 1;
   localparam int RSP_WT_BIT     = RSP_HDR_LSB + PHRASE_W;
   localparam int RSP_THD_LSB    = RSP_WT_BIT + 1;
   localparam int RSP_USED_W     = RSP_THD_LSB + PHRASE_W;

   // Header phrase layout
   localparam int HEIGHT_LSB = 14;
   localparam int HEIGHT_W   = 10;
   localparam int DATA_LSB   = 43;
   localparam int DATA_W     = 21;
   localparam int DWIDTH_LSB = 18;
   localparam int DWIDTH_W   = 10;
   localparam int REM_LSB    = 16;
   localparam int REM_W      = 8;
   localparam int VSCALE_LSB = 8;

   // Remainder unit: one line's worth of vertical remainder
   localparam logic [REM_W-1:0] REM_UNIT = 8'h20;
   localparam logic [REM_W:0]   REM_UNIT_EXT = 9'h020;
   localparam logic [REM_W:0]   REM_BOUND = 9'h120;

   // Object types
   localparam logic [2:0] TYPE_BITMAP = 3'd0;
   localparam logic [2:0] TYPE_SCALED = 3'd1;
   localparam logic [2:0] TYPE_GPU    = 3'd2;
   localparam logic [2:0] TYPE_BRANCH = 3'd3;
   localparam logic [2:0] TYPE_STOP   = 3'd4;

   // Branch condition codes
   localparam logic [2:0] CC_EQUAL   = 3'd0;
   localparam logic [2:0] CC_LESS    = 3'd1;
   localparam logic [2:0] CC_GREATER = 3'd2;
   localparam logic [2:0] CC_OPFLAG  = 3'd3;
   localparam logic [2:0] CC_HALF    = 3'd4;

   // Actions reported on rsp_tuser
   localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FIXED  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SCALED = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_GPU    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd4;

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Classified object, handed from the front to the back
   typedef struct packed {
      logic [NEXT_W-1:0]   next_address;
      logic [ACTION_W-1:0] action;
      logic                raise_irq;
      logic                list_end;
      logic                render;       // walk the remainder loop
      logic                scaled;       // third phrase write-back
      logic                write_header;
      logic [REM_W-1:0]    rem;
      logic [REM_W-1:0]    vscale;       // zero already replaced
      logic [DWIDTH_W-1:0] dwidth;
      logic [PHRASE_W-1:0] header;
      logic [PHRASE_W-1:0] third;
   } olhs_cmd_type;

endpackage

`default_nettype wire

/* src/object_list_header_step_unit.sv */
// Top level of the object list header step unit.
// Depends on olhs_pkg, olhs_front, olhs_fifo and olhs_back.
//
// Usage:
//   req_*  : one object per transaction: address, three phrases, half-line
//            and status bits. A transaction is taken when tvalid and tready
//            are both high.
//   rsp_*  : one result per object, in order: next address, write-backs,
//            action on tuser, list end on tlast.
//   csr_*  : one-bit stop interrupt enable; always ready. Write it only while
//            no object is in flight.
// Flow: the front classifies the object in the accepting cycle and queues
//   it (two entries). The back makes n remainder passes per object: 0 for
//   non-rendered objects, 1 for a fixed bitmap, up to 32 for a scaled
//   bitmap (vscale 1, remainder 0). The back's loop is what sets the rate.
// Reset clears the queue, the back state, the result valid flag and the
//   interrupt enable. When the receiver stalls, the result register holds,
//   the back stops after its loop, the queue fills and req_tready drops.
`default_nettype none

module object_list_header_step_unit import olhs_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Fields from bit 0 up: object_address[23:0], header_phrase[87:24],
   // second_phrase[151:88], third_phrase[215:152], halfline[226:216],
   // op_flag[227], second_half[228], zero fill[231:229]
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   // Fields from bit 0 up: next_address[21:0], raise_irq[22],
   // write_header[23], new_header[87:24], write_third[88],
   // new_third[152:89], zero fill[159:153]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   // object_action[2:0]
   output logic [ACTION_W-1:0]          rsp_tuser,
   // list_end
   output logic                         rsp_tlast,
   // stop_irq_enable
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic                    csr_data
);

   olhs_cmd_type front_cmd;
   olhs_cmd_type queue_cmd;
   logic         front_valid;
   logic         front_ready;
   logic         queue_valid;
   logic         queue_ready;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   // Classify and hold the interrupt enable
   olhs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // Decouple the front from the back
   olhs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_data  (front_cmd),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_data  (queue_cmd)
   );

   // Advance the remainder loop and drive results
   olhs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* src/olhs_front.sv */
// Front part: takes object items, holds the stop interrupt enable, classifies.
// Depends on olhs_pkg.
`default_nettype none

module olhs_front import olhs_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        cmd_valid,
   input  wire logic                   cmd_ready,
   output olhs_cmd_type                cmd
);

   logic                   irq_enable_ff;
   logic                   irq_enable_in;
   logic [ADDR_W-1:0]      addr;
   logic [PHRASE_W-1:0]    p0;
   logic [PHRASE_W-1:0]    p1;
   logic [PHRASE_W-1:0]    p2;
   logic [HALFLINE_W-1:0]  halfline;
   logic                   opf;
   logic                   half2;
   logic [2:0]             obj_type;
   logic [2:0]             cc;
   logic [HALFLINE_W-1:0]  ypos;
   logic [HEIGHT_W-1:0]    height;
   logic                   visible;
   logic                   take;
   logic [NEXT_W-1:0]      seq_addr;
   logic [NEXT_W-1:0]      link_fixed;
   logic [NEXT_W-1:0]      link_branch;
   logic [REM_W-1:0]       rem_raw;
   logic [REM_W-1:0]       vs_raw;

   always_comb begin
      irq_enable_in = irq_enable_ff;
      if (csr_valid) begin
         irq_enable_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_enable_ff <= 1'b0;
      end else begin
         irq_enable_ff <= irq_enable_in;
      end
   end

   assign req_tready = cmd_ready;
   assign cmd_valid  = req_tvalid;

   always_comb begin
      addr     = req_tdata[REQ_ADDR_LSB +: ADDR_W];
      p0       = req_tdata[REQ_HDR_LSB +: PHRASE_W];
      p1       = req_tdata[REQ_SEC_LSB +: PHRASE_W];
      p2       = req_tdata[REQ_THD_LSB +: PHRASE_W];
      halfline = req_tdata[REQ_HL_LSB +: HALFLINE_W];
      opf      = req_tdata[REQ_OPF_BIT];
      half2    = req_tdata[REQ_HALF_BIT];

      obj_type = p0[2:0];
      ypos     = p0[13:3];
      height   = p0[HEIGHT_LSB +: HEIGHT_W];
      cc       = p0[16:14];
      visible  = (halfline >= ypos) && (height != '0);
      rem_raw  = p2[REM_LSB +: REM_W];
      vs_raw   = p2[VSCALE_LSB +: REM_W];

      // Next phrase-aligned object, wrapping inside the address space
      seq_addr    = {addr[NEXT_W-1:3] + 19'd1, 3'b000};
      // Bitmap links lose bit 21; branch links keep it
      link_fixed  = {1'b0, p0[41:24], 3'b000};
      link_branch = {p0[42:24], 3'b000};

      unique case (cc)
         CC_EQUAL:   take = (halfline == ypos) || (ypos == 11'h7FF);
         CC_LESS:    take = halfline < ypos;
         CC_GREATER: take = halfline > ypos;
         CC_OPFLAG:  take = opf;
         CC_HALF:    take = half2;
         default:    take = 1'b0;
      endcase

      cmd              = '0;
      cmd.next_address = seq_addr;
      cmd.action       = ACT_NONE;
      cmd.dwidth       = p1[DWIDTH_LSB +: DWIDTH_W];
      cmd.header       = p0;
      cmd.third        = p2;
      cmd.rem          = '0;
      cmd.vscale       = REM_UNIT;

      unique case (obj_type)
         TYPE_BITMAP: begin
            // Fixed bitmap: exactly one line consumed
            cmd.next_address = link_fixed;
            cmd.render       = visible;
            cmd.write_header = 1'b1;
            cmd.action       = visible ? ACT_FIXED : ACT_NONE;
         end
         TYPE_SCALED: begin
            cmd.next_address = link_fixed;
            cmd.render       = visible;
            cmd.scaled       = 1'b1;
            cmd.write_header = rem_raw < REM_UNIT;
            cmd.rem          = rem_raw;
            cmd.vscale       = (vs_raw == '0) ? REM_UNIT : vs_raw;
            cmd.action       = visible ? ACT_SCALED : ACT_NONE;
         end
         TYPE_GPU: begin
            cmd.action = ACT_GPU;
         end
         TYPE_BRANCH: begin
            if (take) begin
               cmd.next_address = link_branch;
            end
         end
         TYPE_STOP: begin
            cmd.next_address = '0;
            cmd.action       = ACT_STOP;
            cmd.list_end     = 1'b1;
            cmd.raise_irq    = p0[3] && irq_enable_ff;
         end
         default: begin
            cmd.action = ACT_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/olhs_fifo.sv */
// Short command queue between the front and back parts.
// Depends on olhs_pkg for the command type and depth.
`default_nettype none

module olhs_fifo import olhs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         wr_valid,
   output logic              wr_ready,
   input  wire olhs_cmd_type wr_data,
   output logic              rd_valid,
   input  wire logic         rd_ready,
   output olhs_cmd_type      rd_data
);

   olhs_cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;

   localparam logic [QUEUE_PTR_W-1:0] LastPtr = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] FullCount = QUEUE_CNT_W'(QUEUE_DEPTH);

   always_comb begin
      wr_ready = count_ff != FullCount;
      rd_valid = count_ff != '0;
      rd_data  = entry_ff[rd_ptr_ff];
      push     = wr_valid && wr_ready;
      pop      = rd_valid && rd_ready;

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* src/olhs_back.sv */
// Back part: runs the remainder loop for rendered bitmaps and drives the
// registered result channel. Depends on olhs_pkg.
`default_nettype none

module olhs_back import olhs_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    cmd_valid,
   output logic                         cmd_ready,
   input  wire olhs_cmd_type            cmd,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   output logic [ACTION_W-1:0]          rsp_tuser,
   output logic                         rsp_tlast
);

   olhs_cmd_type         cur_ff;
   logic                 busy_ff;
   logic                 busy_in;
   logic [REM_W:0]       rem_ff;
   logic [REM_W:0]       rem_in;
   logic [PHRASE_W-1:0]  hdr_in;
   logic [HEIGHT_W-1:0]  height;
   logic [DATA_W-1:0]    data;
   logic                 need_pass;
   logic                 out_free;
   logic                 finish;
   logic                 load;

   logic                 rsp_valid_ff;
   logic [NEXT_W-1:0]    rsp_next_ff;
   logic [ACTION_W-1:0]  rsp_action_ff;
   logic                 rsp_irq_ff;
   logic                 rsp_wh_ff;
   logic [PHRASE_W-1:0]  rsp_hdr_ff;
   logic                 rsp_wt_ff;
   logic [PHRASE_W-1:0]  rsp_thd_ff;
   logic                 rsp_end_ff;

   always_comb begin
      need_pass = busy_ff && cur_ff.render && (rem_ff < REM_UNIT_EXT);
      out_free  = !rsp_valid_ff || rsp_tready;
      finish    = busy_ff && !need_pass && out_free;
      cmd_ready = !busy_ff || finish;
      load      = cmd_valid && cmd_ready;

      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end

      // One line per pass: height floors at zero, data pointer wraps
      height = cur_ff.header[HEIGHT_LSB +: HEIGHT_W];
      data   = cur_ff.header[DATA_LSB +: DATA_W];
      hdr_in = cur_ff.header;
      hdr_in[HEIGHT_LSB +: HEIGHT_W] = (height == '0) ? '0 : height - 1'b1;
      hdr_in[DATA_LSB +: DATA_W]     = data + DATA_W'(cur_ff.dwidth);
      rem_in = rem_ff + {1'b0, cur_ff.vscale};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= cmd;
         rem_ff <= {1'b0, cmd.rem};
      end else if (need_pass) begin
         cur_ff.header <= hdr_in;
         rem_ff        <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_next_ff   <= cur_ff.next_address;
         rsp_action_ff <= cur_ff.action;
         rsp_irq_ff    <= cur_ff.raise_irq;
         rsp_end_ff    <= cur_ff.list_end;
         rsp_wh_ff     <= cur_ff.render && cur_ff.write_header;
         rsp_hdr_ff    <= (cur_ff.render && cur_ff.write_header) ? cur_ff.header : '0;
         rsp_wt_ff     <= cur_ff.render && cur_ff.scaled;
         rsp_thd_ff    <= (cur_ff.render && cur_ff.scaled) ?
                          {cur_ff.third[PHRASE_W-1:REM_LSB+REM_W],
                           rem_ff[REM_W-1:0] - REM_UNIT,
                           cur_ff.third[REM_LSB-1:0]} : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), rsp_thd_ff, rsp_wt_ff, rsp_hdr_ff,
                        rsp_wh_ff, rsp_irq_ff, rsp_next_ff};

   // Remainder never grows past one unit plus the largest vertical scale
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < REM_BOUND)
      else $error("remainder out of range");

   a_end_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> rsp_action_ff == ACT_STOP && rsp_next_ff == '0)
      else $error("list end without stop object");

   a_third_scaled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wt_ff |-> rsp_action_ff == ACT_SCALED)
      else $error("third phrase write-back without scaled render");

   a_header_render: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wh_ff |-> rsp_action_ff == ACT_FIXED || rsp_action_ff == ACT_SCALED)
      else $error("header write-back without render");

endmodule

`default_nettype wire

/* test/tb_object_list_header_step_unit.sv */
// Self-checking testbench for object_list_header_step_unit: directed and random object headers
// go in on the request stream, and each result is compared field by field with a predictor.
// Depends on olhs_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_object_list_header_step_unit;
   import olhs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // One object header with its fetched phrases and the line context
   typedef struct packed {
      logic [ADDR_W-1:0]     address;
      logic [PHRASE_W-1:0]   header;
      logic [PHRASE_W-1:0]   second_phrase;
      logic [PHRASE_W-1:0]   third_phrase;
      logic [HALFLINE_W-1:0] halfline;
      logic                  op_flag;
      logic                  second_half;
   } list_object_type;

   // What the unit must report for one object
   typedef struct packed {
      logic [NEXT_W-1:0]   next_address;
      logic [ACTION_W-1:0] action;
      logic                raise_irq;
      logic                write_header;
      logic [PHRASE_W-1:0] new_header;
      logic                write_third;
      logic [PHRASE_W-1:0] new_third;
      logic                list_end;
   } walk_result_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [ACTION_W-1:0]    rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_data = 1'b0;

   // Results still owed by the unit, oldest first
   walk_result_type walk_results[$];
   // Our own copy of the stop interrupt enable
   logic         stop_irq_en_copy = 1'b0;
   // Random gaps on the request side and stalls on the result side
   bit           idle_on = 1'b1;
   int           stall_left = 0;
   int           mismatch_count = 0;
   int           result_index = 0;
   int           cycle_count = 0;

   object_list_header_step_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict one step of the list walk.
   function automatic walk_result_type decode_header_step(input list_object_type o);
      walk_result_type   r;
      logic [2:0]        kind;
      logic [10:0]       ypos;
      logic [9:0]        height;
      logic [23:0]       data;
      logic [23:0]       dwidth;
      logic [8:0]        rem;
      logic [8:0]        vscale;
      logic [NEXT_W-1:0] fixed_link;
      logic [NEXT_W-1:0] branch_link;
      logic              taken;
      r      = '0;
      taken  = 1'b0;
      kind   = o.header[2:0];
      ypos   = o.header[13:3];
      height = o.header[HEIGHT_LSB +: HEIGHT_W];
      // Keep pointer and width in byte-phrase units so the 21-bit field wraps at bit 24
      data   = {o.header[DATA_LSB +: DATA_W], 3'b000};
      dwidth = {11'd0, o.second_phrase[DWIDTH_LSB +: DWIDTH_W], 3'b000};
      // Bitmap links never keep bit 21; branch links do
      fixed_link  = {1'b0, o.header[41:24], 3'b000};
      branch_link = {o.header[42:24], 3'b000};
      // Default: the following object, wrapping at the top of the 22-bit space
      r.next_address = {o.address[NEXT_W-1:3], 3'b000} + NEXT_W'(8);
      case (kind)
         TYPE_BITMAP: begin
            if (o.halfline >= ypos && height != 0) begin
               r.action       = ACT_FIXED;
               data           = data + dwidth;
               r.write_header = 1'b1;
               r.new_header   = {data[23:3], o.header[42:24], height - 10'd1, o.header[13:0]};
            end
            r.next_address = fixed_link;
         end
         TYPE_SCALED: begin
            if (o.halfline >= ypos && height != 0) begin
               r.action = ACT_SCALED;
               rem      = {1'b0, o.third_phrase[REM_LSB +: REM_W]};
               vscale   = {1'b0, o.third_phrase[VSCALE_LSB +: REM_W]};
               if (vscale == 0) vscale = REM_UNIT_EXT;
               if (rem < REM_UNIT_EXT) begin
                  // Consume lines until the remainder covers one more; height floors at zero
                  while (rem < REM_UNIT_EXT) begin
                     rem  = rem + vscale;
                     if (height != 0) height = height - 10'd1;
                     data = data + dwidth;
                  end
                  r.write_header = 1'b1;
                  r.new_header   = {data[23:3], o.header[42:24], height, o.header[13:0]};
               end
               rem           = rem - REM_UNIT_EXT;
               r.write_third = 1'b1;
               r.new_third   = {o.third_phrase[63:24], rem[7:0], o.third_phrase[15:0]};
            end
            r.next_address = fixed_link;
         end
         TYPE_GPU: r.action = ACT_GPU;
         TYPE_BRANCH: begin
            case (o.header[16:14])
               CC_EQUAL:   taken = (o.halfline == ypos) || (ypos == '1);
               CC_LESS:    taken = o.halfline < ypos;
               CC_GREATER: taken = o.halfline > ypos;
               CC_OPFLAG:  taken = o.op_flag;
               CC_HALF:    taken = o.second_half;
               default:    taken = 1'b0;
            endcase
            if (taken) r.next_address = branch_link;
         end
         TYPE_STOP: begin
            r.action       = ACT_STOP;
            r.list_end     = 1'b1;
            r.next_address = '0;
            r.raise_irq    = o.header[3] & stop_irq_en_copy;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [PHRASE_W-1:0] make_header(input logic [2:0] kind,
      input logic [10:0] ypos, input logic [9:0] height, input logic [18:0] link,
      input logic [20:0] data);
      return {data, link, height, ypos, kind};
   endfunction

   function automatic logic [PHRASE_W-1:0] random_header(input logic [2:0] kind);
      logic [PHRASE_W-1:0] p;
      p      = {$urandom, $urandom};
      p[2:0] = kind;
      return p;
   endfunction

   function automatic logic [PHRASE_W-1:0] with_dwidth(input logic [9:0] dw);
      logic [PHRASE_W-1:0] p;
      p = {$urandom, $urandom};
      p[DWIDTH_LSB +: DWIDTH_W] = dw;
      return p;
   endfunction

   function automatic logic [PHRASE_W-1:0] make_third(input logic [7:0] vs,
      input logic [7:0] rem);
      logic [PHRASE_W-1:0] p;
      p = {$urandom, $urandom};
      p[VSCALE_LSB +: REM_W] = vs;
      p[REM_LSB +: REM_W]    = rem;
      return p;
   endfunction

   function automatic list_object_type object_of(input logic [ADDR_W-1:0] address,
      input logic [PHRASE_W-1:0] header, input logic [PHRASE_W-1:0] second_phrase,
      input logic [PHRASE_W-1:0] third_phrase, input logic [HALFLINE_W-1:0] halfline,
      input logic op_flag, input logic second_half);
      list_object_type o;
      o.address       = address;
      o.header        = header;
      o.second_phrase = second_phrase;
      o.third_phrase  = third_phrase;
      o.halfline      = halfline;
      o.op_flag       = op_flag;
      o.second_half   = second_half;
      return o;
   endfunction

   // Random object, weighted toward visible bitmaps, slow scaled loops and branch edges.
   function automatic list_object_type random_object();
      list_object_type o;
      logic [2:0]   kind;
      logic [10:0]  ypos;
      logic [9:0]   height;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      kind = TYPE_BITMAP;
      else if (pick < 55) kind = TYPE_SCALED;
      else if (pick < 75) kind = TYPE_BRANCH;
      else if (pick < 82) kind = TYPE_GPU;
      else if (pick < 92) kind = TYPE_STOP;
      else                kind = 3'($urandom_range(TYPE_STOP + 1, 7));

      ypos = ($urandom_range(0, 15) == 0) ? 11'h7FF : 11'($urandom);
      case ($urandom_range(0, 7))
         0:       height = '0;
         1, 2, 3: height = 10'($urandom_range(1, 4));
         default: height = 10'($urandom);
      endcase

      o.header = random_header(kind);
      o.header[13:3] = ypos;
      if (kind != TYPE_BRANCH) o.header[HEIGHT_LSB +: HEIGHT_W] = height;

      o.address = 24'($urandom);
      if ($urandom_range(0, 15) == 0) o.address[21:3] = '1;

      o.second_phrase = ($urandom_range(0, 3) == 0) ?
                        with_dwidth(10'($urandom_range(0, 3))) : {$urandom, $urandom};
      o.third_phrase  = {$urandom, $urandom};
      if (kind == TYPE_SCALED) begin
         case ($urandom_range(0, 3))
            0:       o.third_phrase[VSCALE_LSB +: REM_W] = '0;
            1:       o.third_phrase[VSCALE_LSB +: REM_W] = 8'($urandom_range(1, 4));
            default: ;
         endcase
         if ($urandom_range(0, 1) == 0)
            o.third_phrase[REM_LSB +: REM_W] = 8'($urandom_range(0, 31));
      end

      // Land near ypos most of the time so every comparison goes both ways
      case ($urandom_range(0, 3))
         0:       o.halfline = 11'($urandom);
         1:       o.halfline = ypos;
         2:       o.halfline = ypos + 11'($urandom_range(1, 3));
         default: o.halfline = ypos - 11'($urandom_range(1, 3));
      endcase
      o.op_flag     = 1'($urandom);
      o.second_half = 1'($urandom);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [PHRASE_W-1:0] got,
      input logic [PHRASE_W-1:0] want);
      $display("[%0t] result %0d: %s got %h, want %h", $time, result_index, what, got, want);
      mismatch_count++;
   endtask

   // Send one object; queue its prediction when the transaction is taken.
   task automatic send_object(input list_object_type o);
      logic [REQ_TDATA_W-1:0] word;
      walk_result_type        want;
      word = '0;
      word[REQ_ADDR_LSB +: ADDR_W]     = o.address;
      word[REQ_HDR_LSB +: PHRASE_W]    = o.header;
      word[REQ_SEC_LSB +: PHRASE_W]    = o.second_phrase;
      word[REQ_THD_LSB +: PHRASE_W]    = o.third_phrase;
      word[REQ_HL_LSB +: HALFLINE_W]   = o.halfline;
      word[REQ_OPF_BIT]                = o.op_flag;
      word[REQ_HALF_BIT]               = o.second_half;
      want = decode_header_step(o);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      walk_results.push_back(want);
   endtask

   // Hold the request side until every owed result has come back.
   task automatic finish_walk();
      req_tvalid <= 1'b0;
      while (walk_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_stop_irq_enable(input logic enable);
      csr_valid <= 1'b1;
      csr_data  <= enable;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      stop_irq_en_copy = enable;
   endtask

   task automatic test_bitmap_objects();
      // Last line of the image: data pointer wraps, link bit 21 is cleared
      send_object(object_of(24'h000010,
         make_header(TYPE_BITMAP, 11'd100, 10'd1, 19'h7FFFF, 21'h1FFFFF),
         with_dwidth(10'h3FF), {$urandom, $urandom}, 11'd100, 1'b0, 1'b0));
      // No height left: nothing to render
      send_object(object_of(24'h000123,
         make_header(TYPE_BITMAP, 11'd5, 10'd0, 19'h0ABCD, 21'h012345),
         with_dwidth(10'd7), {$urandom, $urandom}, 11'd600, 1'b1, 1'b1));
      // Not yet on screen
      send_object(object_of(24'hFFFFFF,
         make_header(TYPE_BITMAP, 11'h7FF, 10'h3FF, 19'h40000, 21'h0),
         with_dwidth(10'd1), {$urandom, $urandom}, 11'd0, 1'b0, 1'b1));
      // Extremes of every header field, zero width
      send_object(object_of(24'h3FFFF8,
         make_header(TYPE_BITMAP, 11'd0, 10'h3FF, 19'h7FFFF, 21'h1FFFFF),
         with_dwidth(10'd0), {$urandom, $urandom}, 11'h7FF, 1'b1, 1'b1));
      send_object(object_of(24'h000000,
         make_header(TYPE_BITMAP, 11'd0, 10'd2, 19'h0, 21'h0),
         with_dwidth(10'd3), {$urandom, $urandom}, 11'd0, 1'b0, 1'b0));
   endtask

   task automatic test_scaled_objects();
      // Zero vscale acts as one full line
      send_object(object_of(24'h000200,
         make_header(TYPE_SCALED, 11'd20, 10'd3, 19'h12345, 21'h000400),
         with_dwidth(10'd12), make_third(8'd0, 8'd0), 11'd20, 1'b0, 1'b0));
      // Slowest loop: 32 passes, height runs out and floors at zero
      send_object(object_of(24'h000208,
         make_header(TYPE_SCALED, 11'd0, 10'd5, 19'h7FFFF, 21'h1FFFF0),
         with_dwidth(10'd1), make_third(8'd1, 8'd0), 11'd300, 1'b1, 1'b0));
      // Remainder already covers a line: third phrase only
      send_object(object_of(24'h000210,
         make_header(TYPE_SCALED, 11'h7FF, 10'd10, 19'h00001, 21'h000001),
         with_dwidth(10'd9), make_third(8'h10, 8'hFF), 11'h7FF, 1'b0, 1'b1));
      // Not yet on screen
      send_object(object_of(24'h000218,
         make_header(TYPE_SCALED, 11'h400, 10'd10, 19'h00010, 21'h000010),
         with_dwidth(10'd9), make_third(8'd0, 8'd0), 11'h3FF, 1'b1, 1'b1));
      // Largest vscale, remainder one short of a line, data wraps
      send_object(object_of(24'h000220,
         make_header(TYPE_SCALED, 11'd999, 10'h3FF, 19'h40001, 21'h1FFFFF),
         with_dwidth(10'h3FF), make_third(8'hFF, 8'h1F), 11'd1000, 1'b0, 1'b0));
      // No height left
      send_object(object_of(24'h000228,
         make_header(TYPE_SCALED, 11'd1, 10'd0, 19'h2AAAA, 21'h155555),
         with_dwidth(10'd4), make_third(8'd2, 8'd0), 11'd50, 1'b0, 1'b0));
   endtask

   task automatic test_branch_objects();
      int cc;
      // Taken on equal; branch link keeps bit 21
      send_object(object_of(24'h000100,
         make_header(TYPE_BRANCH, 11'd300, {7'h55, CC_EQUAL}, 19'h7FFFF, 21'h0),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'd300, 1'b0, 1'b0));
      // ypos of all ones always matches
      send_object(object_of(24'h000108,
         make_header(TYPE_BRANCH, 11'h7FF, {7'h2A, CC_EQUAL}, 19'h01234, 21'h1FFFFF),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'd5, 1'b0, 1'b0));
      // Untaken at the very top of the address range: the walk wraps to zero
      send_object(object_of(24'hFFFFFF,
         make_header(TYPE_BRANCH, 11'd10, {7'h00, CC_EQUAL}, 19'h55555, 21'h0),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'd11, 1'b1, 1'b1));
      send_object(object_of(24'h000110,
         make_header(TYPE_BRANCH, 11'd200, {7'h7F, CC_LESS}, 19'h00100, 21'h0),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'd199, 1'b0, 1'b0));
      send_object(object_of(24'h000118,
         make_header(TYPE_BRANCH, 11'd200, {7'h00, CC_GREATER}, 19'h00200, 21'h0),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'd201, 1'b0, 1'b0));
      send_object(object_of(24'h000120,
         make_header(TYPE_BRANCH, 11'd0, {7'h11, CC_OPFLAG}, 19'h00300, 21'h0),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'd7, 1'b1, 1'b0));
      send_object(object_of(24'h000128,
         make_header(TYPE_BRANCH, 11'd0, {7'h22, CC_HALF}, 19'h00400, 21'h0),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'd7, 1'b0, 1'b1));
      // Codes past the half-line test never branch, whatever the inputs say
      for (cc = CC_HALF + 1; cc < 8; cc++)
         send_object(object_of(24'h000130,
            make_header(TYPE_BRANCH, 11'd40, {7'h3C, 3'(cc)}, 19'h00500, 21'h0),
            {$urandom, $urandom}, {$urandom, $urandom}, 11'd40, 1'b1, 1'b1));
   endtask

   task automatic test_other_objects();
      int kind;
      // GPU object at the top of memory: the next address wraps to zero
      send_object(object_of(24'h3FFFFF, random_header(TYPE_GPU),
         {$urandom, $urandom}, {$urandom, $urandom}, 11'($urandom), 1'b0, 1'b1));
      // Stop with its interrupt bit while the enable is still off
      send_object(object_of(24'h000400, random_header(TYPE_STOP) | 64'h8,
         {$urandom, $urandom}, {$urandom, $urandom}, 11'($urandom), 1'b1, 1'b0));
      // Unused types do nothing but advance
      for (kind = TYPE_STOP + 1; kind < 8; kind++)
         send_object(object_of(24'($urandom), random_header(3'(kind)),
            {$urandom, $urandom}, {$urandom, $urandom}, 11'($urandom), 1'b1, 1'b1));
   endtask

   task automatic test_stop_interrupt();
      finish_walk();
      write_stop_irq_enable(1'b1);
      send_object(object_of(24'h000500, random_header(TYPE_STOP) | 64'h8,
         {$urandom, $urandom}, {$urandom, $urandom}, 11'($urandom), 1'b0, 1'b0));
      send_object(object_of(24'h000508, random_header(TYPE_STOP) & ~64'h8,
         {$urandom, $urandom}, {$urandom, $urandom}, 11'($urandom), 1'b1, 1'b1));
      finish_walk();
      write_stop_irq_enable(1'b0);
      send_object(object_of(24'h000510, random_header(TYPE_STOP) | 64'h8,
         {$urandom, $urandom}, {$urandom, $urandom}, 11'($urandom), 1'b0, 1'b1));
      finish_walk();
      write_stop_irq_enable(1'b1);
   endtask

   // Random objects; at pause_at, hold the sender until the unit has fully drained.
   task automatic test_random_objects(input int count, input bit idling, input int pause_at);
      idle_on = idling;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) finish_walk();
         send_object(random_object());
      end
   endtask

   // Result side: stall in random bursts while idling is on
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      walk_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_index++;
         if (walk_results.size() == 0) begin
            report_mismatch("result with no object in flight",
               64'(rsp_tdata[RSP_NEXT_LSB +: NEXT_W]), '0);
         end else begin
            want = walk_results.pop_front();
            if (rsp_tdata[RSP_NEXT_LSB +: NEXT_W] !== want.next_address)
               report_mismatch("next_address", 64'(rsp_tdata[RSP_NEXT_LSB +: NEXT_W]),
                  64'(want.next_address));
            if (rsp_tuser !== want.action)
               report_mismatch("object_action", 64'(rsp_tuser), 64'(want.action));
            if (rsp_tdata[RSP_IRQ_BIT] !== want.raise_irq)
               report_mismatch("raise_irq", 64'(rsp_tdata[RSP_IRQ_BIT]), 64'(want.raise_irq));
            if (rsp_tdata[RSP_WH_BIT] !== want.write_header)
               report_mismatch("write_header", 64'(rsp_tdata[RSP_WH_BIT]),
                  64'(want.write_header));
            if (rsp_tdata[RSP_HDR_LSB +: PHRASE_W] !== want.new_header)
               report_mismatch("new_header", rsp_tdata[RSP_HDR_LSB +: PHRASE_W],
                  want.new_header);
            if (rsp_tdata[RSP_WT_BIT] !== want.write_third)
               report_mismatch("write_third", 64'(rsp_tdata[RSP_WT_BIT]), 64'(want.write_third));
            if (rsp_tdata[RSP_THD_LSB +: PHRASE_W] !== want.new_third)
               report_mismatch("new_third", rsp_tdata[RSP_THD_LSB +: PHRASE_W], want.new_third);
            if (rsp_tlast !== want.list_end)
               report_mismatch("list_end", 64'(rsp_tlast), 64'(want.list_end));
         end
      end
   end

   // Drop the run if the unit hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("object_list_header_step_unit regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bitmap_objects();
      test_scaled_objects();
      test_branch_objects();
      test_other_objects();
      test_stop_interrupt();

      // Random lists across both enable settings, with and without idling;
      // the final stretch streams flat out
      test_random_objects(500, 1'b1, 250);
      finish_walk();
      write_stop_irq_enable(1'b0);
      test_random_objects(200, 1'b0, -1);
      test_random_objects(400, 1'b1, -1);
      finish_walk();
      write_stop_irq_enable(1'b1);
      test_random_objects(320, 1'b0, -1);

      finish_walk();
      // Leave room for any stray result to show up
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("object_list_header_step_unit regression: pass");
      else
         $display("object_list_header_step_unit regression: fail");
      $finish;
   end

endmodule
